/* rtl/wlc_pkg.sv */
// Shared types and constants for the window/level colormap.
// No dependencies; imported by window_level_colormap.
`default_nettype none

package wlc_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int RAMP_BITS         = 8;
    localparam int WINDOW_HIGH_RESET = 255;

    localparam logic [RAMP_BITS-1:0] CHAN_MIN = '0;
    localparam logic [RAMP_BITS-1:0] CHAN_MAX = '1;

    // configuration register indexes
    localparam logic [1:0] REG_WINDOW_LOW  = 2'd0;
    localparam logic [1:0] REG_WINDOW_HIGH = 2'd1;
    localparam logic [1:0] REG_COLOR_MODE  = 2'd2;

    typedef enum logic [2:0] {
        MODE_LUMA    = 3'd0,
        MODE_INVERSE = 3'd1,
        MODE_RED     = 3'd2,
        MODE_GREEN   = 3'd3,
        MODE_BLUE    = 3'd4,
        MODE_HOT     = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ZONE_BELOW  = 2'd0,
        ZONE_INSIDE = 2'd1,
        ZONE_ABOVE  = 2'd2
    } zone_t;

    // channel value for a zone: low colour, ramp value, high colour
    function automatic logic [RAMP_BITS-1:0] zone_level(
        input zone_t                zone,
        input logic [RAMP_BITS-1:0] ramp,
        input logic [RAMP_BITS-1:0] low_color,
        input logic [RAMP_BITS-1:0] high_color
    );
        logic [RAMP_BITS-1:0] level;
        level = high_color;
        unique case (zone)
            ZONE_BELOW:  level = low_color;
            ZONE_INSIDE: level = ramp;
            default:     level = high_color;
        endcase
        return level;
    endfunction

endpackage

`default_nettype wire

/* rtl/window_level_colormap.sv */
// Window/level colormap: signed sample in, 8-bit RGB out, one request per clock while the output is not stalled.
// Depends on wlc_pkg (types, register indexes, zone_level).
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  sample   | sample_valid, sample_ready, sample        | in
//  color    | color_valid, color_ready, red/green/blue  | out
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// Throughput is one sample per clock while the output is not stalled; a result
// passes through one window-compare stage, one scaling stage, eight
// restoring-division stages (one quotient bit each) and the output register.
// The whole pipeline advances together when the output register is empty or taken.
// Reset clears the valid bits and loads window 0..255 in luminance mode.
// cfg is always ready; writes land at once.
`default_nettype none

module window_level_colormap
    import wlc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          sample_valid,
    output logic                               sample_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,

    output logic                               color_valid,
    input  wire logic                          color_ready,
    output logic             [RAMP_BITS-1:0]   red,
    output logic             [RAMP_BITS-1:0]   green,
    output logic             [RAMP_BITS-1:0]   blue,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [1:0]             cfg_index,
    input  wire logic        [SAMPLE_BITS-1:0] cfg_data
);

    localparam int RW    = SAMPLE_BITS + 10;   // holds 510*num + den
    localparam int DW    = SAMPLE_BITS + 1;    // holds 2*den
    localparam int NSTEP = RAMP_BITS;

    // ---------------- configuration ----------------
    logic signed [SAMPLE_BITS-1:0] window_low_reg;
    logic signed [SAMPLE_BITS-1:0] window_high_reg;
    logic        [2:0]             color_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= '0;
            window_high_reg <= SAMPLE_BITS'(WINDOW_HIGH_RESET);
            color_mode_reg  <= MODE_LUMA;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WINDOW_LOW:  window_low_reg  <= cfg_data;
                REG_WINDOW_HIGH: window_high_reg <= cfg_data;
                REG_COLOR_MODE:  color_mode_reg  <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic color_valid_reg;
    logic advance;

    assign advance      = !color_valid_reg || color_ready;
    assign sample_ready = advance;

    // ---------------- stage 0: window compare ----------------
    // on the ramp every difference lies in 0..span, so the low bits suffice
    logic [SAMPLE_BITS-1:0] diff_lo, diff_hi, span;
    zone_t                  s0_zone_next;
    logic [SAMPLE_BITS-1:0] s0_num_next;

    assign diff_lo = sample - window_low_reg;
    assign diff_hi = window_high_reg - sample;
    assign span    = window_high_reg - window_low_reg;

    always_comb
    begin
        priority if (sample > window_high_reg)
            s0_zone_next = ZONE_ABOVE;
        else if (sample < window_low_reg)
            s0_zone_next = ZONE_BELOW;
        else
            s0_zone_next = ZONE_INSIDE;

        // numerator is zero off the ramp so the divider sees in-range values
        if (s0_zone_next != ZONE_INSIDE)
            s0_num_next = '0;
        else if (color_mode_reg == MODE_INVERSE)
            s0_num_next = diff_hi;
        else
            s0_num_next = diff_lo;
    end

    logic                   s0_valid_reg;
    zone_t                  s0_zone_reg;
    logic [SAMPLE_BITS-1:0] s0_num_reg;
    logic [SAMPLE_BITS-1:0] s0_den_reg;

    // ---------------- stage 1: scale to 510*num + den over 2*den ----------------
    logic [RW-1:0] scaled_next;
    logic [DW-1:0] divisor_next;

    assign scaled_next  = (RW'(s0_num_reg) << 9) - (RW'(s0_num_reg) << 1) + RW'(s0_den_reg);
    // zero-width window: numerator is 0 too, any nonzero divisor gives 0
    assign divisor_next = (s0_den_reg == '0) ? DW'(1) : {s0_den_reg, 1'b0};

    // ---------------- division stages ----------------
    logic                 dv_valid_reg [0:NSTEP];
    zone_t                dv_zone_reg  [0:NSTEP];
    logic [RW-1:0]        dv_rem_reg   [0:NSTEP];
    logic [DW-1:0]        dv_dvs_reg   [0:NSTEP];
    logic [RAMP_BITS-1:0] dv_quo_reg   [0:NSTEP];

    logic [RW-1:0]        rem_next [1:NSTEP];
    logic [RAMP_BITS-1:0] quo_next [1:NSTEP];

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        logic [RW-1:0] trial;
        logic          take;

        assign trial           = RW'(dv_dvs_reg[i]) << (NSTEP - 1 - i);
        assign take            = dv_rem_reg[i] >= trial;
        assign rem_next[i+1]   = take ? (dv_rem_reg[i] - trial) : dv_rem_reg[i];
        assign quo_next[i+1]   = {dv_quo_reg[i][RAMP_BITS-2:0], take};
    end

    // ---------------- output stage ----------------
    logic [RAMP_BITS-1:0] ramp;
    zone_t                out_zone;
    logic [RAMP_BITS-1:0] red_next, green_next, blue_next;
    logic [RAMP_BITS-1:0] red_reg, green_reg, blue_reg;

    assign ramp     = dv_quo_reg[NSTEP];
    assign out_zone = dv_zone_reg[NSTEP];

    always_comb
    begin
        red_next   = CHAN_MIN;
        green_next = CHAN_MIN;
        blue_next  = CHAN_MIN;
        unique case (color_mode_reg)
            MODE_INVERSE:
            begin
                red_next   = zone_level(out_zone, ramp, CHAN_MAX, CHAN_MIN);
                green_next = red_next;
                blue_next  = red_next;
            end
            MODE_RED:
                red_next   = zone_level(out_zone, ramp, CHAN_MIN, CHAN_MAX);
            MODE_GREEN:
                green_next = zone_level(out_zone, ramp, CHAN_MIN, CHAN_MAX);
            MODE_BLUE:
                blue_next  = zone_level(out_zone, ramp, CHAN_MIN, CHAN_MAX);
            MODE_HOT:
            begin
                red_next   = (out_zone == ZONE_BELOW) ? CHAN_MIN : CHAN_MAX;
                green_next = zone_level(out_zone, ramp, CHAN_MIN, CHAN_MAX);
            end
            default:
            begin
                red_next   = zone_level(out_zone, ramp, CHAN_MIN, CHAN_MAX);
                green_next = red_next;
                blue_next  = red_next;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            color_valid_reg <= 1'b0;
            for (int i = 0; i <= NSTEP; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            s0_valid_reg    <= sample_valid;
            dv_valid_reg[0] <= s0_valid_reg;
            for (int i = 1; i <= NSTEP; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
            color_valid_reg <= dv_valid_reg[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_zone_reg   <= s0_zone_next;
            s0_num_reg    <= s0_num_next;
            s0_den_reg    <= span;

            dv_zone_reg[0] <= s0_zone_reg;
            dv_rem_reg[0]  <= scaled_next;
            dv_dvs_reg[0]  <= divisor_next;
            dv_quo_reg[0]  <= '0;
            for (int i = 1; i <= NSTEP; i++)
            begin
                dv_zone_reg[i] <= dv_zone_reg[i-1];
                dv_rem_reg[i]  <= rem_next[i];
                dv_dvs_reg[i]  <= dv_dvs_reg[i-1];
                dv_quo_reg[i]  <= quo_next[i];
            end

            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign color_valid = color_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;

    // ---------------- assertions ----------------
    // quotient fits in eight bits
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[0] |-> (dv_rem_reg[0] < (RW'(dv_dvs_reg[0]) << NSTEP)))
        else $error("dividend out of range for 8-bit quotient");

    // restoring steps leave a proper remainder
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[NSTEP] |-> (dv_rem_reg[NSTEP] < RW'(dv_dvs_reg[NSTEP])))
        else $error("final remainder not below divisor");

    // a taken request always enters stage 0
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> s0_valid_reg)
        else $error("accepted request lost at entry");

    // a stall freezes the pipeline
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (color_valid && !color_ready) |=> $stable(dv_valid_reg[NSTEP]) && $stable(s0_valid_reg))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire
